FILE: rtl/rsu_pkg.sv
package rsu_pkg;

  // Transaction payloads.
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] sample;
    logic [3:0]         stat_select;
  } item_t;

  typedef struct packed {
    logic signed [63:0] stat_value;
    logic               is_missing;
  } result_t;

  // Operation codes.
  localparam logic [1:0] OPC_ADD   = 2'd0;
  localparam logic [1:0] OPC_QUERY = 2'd1;
  localparam logic [1:0] OPC_CLEAR = 2'd2;

  // Statistic indexes.
  localparam logic [3:0] STAT_LOWEST  = 4'd0;
  localparam logic [3:0] STAT_MEAN    = 4'd1;
  localparam logic [3:0] STAT_SUM     = 4'd2;
  localparam logic [3:0] STAT_SUMSQ   = 4'd3;
  localparam logic [3:0] STAT_SSTD    = 4'd4;
  localparam logic [3:0] STAT_PSTD    = 4'd5;
  localparam logic [3:0] STAT_STDERR  = 4'd6;
  localparam logic [3:0] STAT_CV      = 4'd7;
  localparam logic [3:0] STAT_VAR     = 4'd8;
  localparam logic [3:0] STAT_HIGHEST = 4'd9;
  localparam logic [3:0] STAT_TSS     = 4'd10;
  localparam logic [3:0] STAT_QMEAN   = 4'd11;
  localparam logic [3:0] STAT_RANGE   = 4'd12;
  localparam logic [3:0] STAT_COUNT   = 4'd13;

  // Missing value after reset, -9999999.0 in Q31.16.
  localparam logic [47:0] MISSING_RESET = 48'hFF67_6981_0000;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_S2, ST_D, ST_FIXD, ST_NUMA, ST_NUMB, ST_DENA, ST_DENB,
    ST_DIV, ST_SQRT, ST_OUT
  } state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    DP_NOP, DP_ADD, DP_CLEAR, DP_QUERY, DP_LOAD, DP_MUL, DP_FIXD,
    DP_DIV, DP_SQRT, DP_OUT
  } dp_op_t;

  // Wide operand sources.
  typedef enum logic [3:0] {
    SRC_ZERO, SRC_ABS16, SRC_SQ16, SRC_SQ32, SRC_D16, SRC_D32, SRC_N,
    SRC_NUM32, SRC_ABS, SRC_D, SRC_DEN, SRC_S2, SRC_SQ
  } src_t;

  // Multiplier operand sources.
  typedef enum logic [1:0] {
    MB_N, MB_M, MB_ABS
  } mb_t;

  // Destination registers.
  typedef enum logic [2:0] {
    DST_S2, DST_D, DST_NUM, DST_DEN, DST_RES
  } dst_t;

  typedef struct packed {
    dp_op_t op;
    src_t   src;
    mb_t    mb;
    dst_t   dst;
  } cmd_t;

  typedef struct packed {
    logic       done;
    logic       direct;
    logic       cv_var;
    logic [3:0] sel;
  } status_t;

endpackage

FILE: rtl/running_statistics_unit_core.sv
// Running count, minimum, maximum, sum and sum of squares of signed samples,
// with a query port for fourteen derived statistics in signed Q47.16.
// Input transactions (item_valid/item_ready) carry an operation: add a sample,
// query a statistic, or clear the store. Only queries produce a result
// transaction on result_valid/result_ready.
// Add and clear leave item_ready high, so they can follow back to back.
// Lowest, highest, range, count, unused statistic indexes, a coefficient of
// variation of all-zero samples and every statistic of an empty store skip
// the arithmetic and go from the first query state straight to the output
// state. The other queries run on a shared shift-add multiplier, a restoring
// divider and a digit-by-digit square root over working registers of
// W = 3C+2S+32 bits (S = SAMPLE_BITS, C = COUNT_BITS).
// Reset empties the store and loads the missing value with -9999999.0;
// cfg_we writes a new missing value at once and it survives a clear.
// The result sits in an output register: new transactions are accepted while
// it waits, and a finished query holds in its last step until the receiver
// has taken the previous result.
module running_statistics_unit_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [47:0]      cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  rsu_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output rsu_pkg::result_t result
);

  rsu_pkg::cmd_t    cmd;
  rsu_pkg::status_t status;

  // Sequencer.
  rsu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (item.operation),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Store and arithmetic.
  rsu_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

FILE: rtl/rsu_ctrl.sv
module rsu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [1:0]        operation,
  output logic              result_valid,
  input  logic              result_ready,
  input  rsu_pkg::status_t  status,
  output rsu_pkg::cmd_t     cmd
);

  rsu_pkg::state_t state, state_next;
  logic            result_valid_next;
  logic            accept;
  logic [3:0]      kind;

  assign item_ready = (state == rsu_pkg::ST_IDLE);
  assign accept     = item_valid && item_ready;

  // A coefficient of variation with zero sum and nonzero squares is the variance.
  assign kind = (status.sel == rsu_pkg::STAT_CV && status.cv_var) ? rsu_pkg::STAT_VAR
                                                                  : status.sel;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rsu_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next        = state;
    result_valid_next = result_valid && !result_ready;
    cmd = '{op: rsu_pkg::DP_NOP, src: rsu_pkg::SRC_ZERO, mb: rsu_pkg::MB_N,
            dst: rsu_pkg::DST_RES};
    case (state)
      rsu_pkg::ST_IDLE: begin
        if (accept) begin
          case (operation)
            rsu_pkg::OPC_ADD:   cmd.op = rsu_pkg::DP_ADD;
            rsu_pkg::OPC_CLEAR: cmd.op = rsu_pkg::DP_CLEAR;
            rsu_pkg::OPC_QUERY: begin
              cmd.op     = rsu_pkg::DP_QUERY;
              state_next = rsu_pkg::ST_S2;
            end
            default: cmd.op = rsu_pkg::DP_NOP;
          endcase
        end
      end
      rsu_pkg::ST_S2: begin
        if (status.direct) begin
          state_next = rsu_pkg::ST_OUT;
        end else begin
          cmd = '{op: rsu_pkg::DP_MUL, src: rsu_pkg::SRC_ABS, mb: rsu_pkg::MB_ABS,
                  dst: rsu_pkg::DST_S2};
          if (status.done) state_next = rsu_pkg::ST_D;
        end
      end
      rsu_pkg::ST_D: begin
        cmd = '{op: rsu_pkg::DP_MUL, src: rsu_pkg::SRC_SQ, mb: rsu_pkg::MB_N,
                dst: rsu_pkg::DST_D};
        if (status.done) state_next = rsu_pkg::ST_FIXD;
      end
      rsu_pkg::ST_FIXD: begin
        cmd.op     = rsu_pkg::DP_FIXD;
        state_next = rsu_pkg::ST_NUMA;
      end
      rsu_pkg::ST_NUMA: begin
        cmd.op  = rsu_pkg::DP_LOAD;
        cmd.dst = rsu_pkg::DST_NUM;
        case (kind)
          rsu_pkg::STAT_MEAN:  cmd.src = rsu_pkg::SRC_ABS16;
          rsu_pkg::STAT_SUM: begin
            cmd.src = rsu_pkg::SRC_ABS16;
            cmd.dst = rsu_pkg::DST_RES;
          end
          rsu_pkg::STAT_SUMSQ: begin
            cmd.src = rsu_pkg::SRC_SQ16;
            cmd.dst = rsu_pkg::DST_RES;
          end
          rsu_pkg::STAT_SSTD, rsu_pkg::STAT_PSTD, rsu_pkg::STAT_STDERR:
            cmd.src = rsu_pkg::SRC_D32;
          rsu_pkg::STAT_CV: begin
            cmd.op  = rsu_pkg::DP_MUL;
            cmd.src = rsu_pkg::SRC_D;
            cmd.mb  = rsu_pkg::MB_N;
          end
          rsu_pkg::STAT_VAR, rsu_pkg::STAT_TSS: cmd.src = rsu_pkg::SRC_D16;
          default: cmd.src = rsu_pkg::SRC_SQ32;
        endcase
        if (status.done) state_next = rsu_pkg::ST_NUMB;
      end
      rsu_pkg::ST_NUMB: begin
        if (kind == rsu_pkg::STAT_CV) begin
          cmd.op  = rsu_pkg::DP_LOAD;
          cmd.src = rsu_pkg::SRC_NUM32;
          cmd.dst = rsu_pkg::DST_NUM;
        end
        state_next = rsu_pkg::ST_DENA;
      end
      rsu_pkg::ST_DENA: begin
        cmd.dst = rsu_pkg::DST_DEN;
        case (kind)
          rsu_pkg::STAT_MEAN, rsu_pkg::STAT_TSS, rsu_pkg::STAT_QMEAN: begin
            cmd.op  = rsu_pkg::DP_LOAD;
            cmd.src = rsu_pkg::SRC_N;
          end
          rsu_pkg::STAT_SSTD, rsu_pkg::STAT_VAR: begin
            cmd.op  = rsu_pkg::DP_MUL;
            cmd.src = rsu_pkg::SRC_N;
            cmd.mb  = rsu_pkg::MB_M;
          end
          rsu_pkg::STAT_PSTD, rsu_pkg::STAT_STDERR: begin
            cmd.op  = rsu_pkg::DP_MUL;
            cmd.src = rsu_pkg::SRC_N;
            cmd.mb  = rsu_pkg::MB_N;
          end
          rsu_pkg::STAT_CV: begin
            cmd.op  = rsu_pkg::DP_MUL;
            cmd.src = rsu_pkg::SRC_S2;
            cmd.mb  = rsu_pkg::MB_M;
          end
          default: cmd.op = rsu_pkg::DP_NOP;
        endcase
        if (status.done) state_next = rsu_pkg::ST_DENB;
      end
      rsu_pkg::ST_DENB: begin
        if (kind == rsu_pkg::STAT_STDERR) begin
          cmd = '{op: rsu_pkg::DP_MUL, src: rsu_pkg::SRC_DEN, mb: rsu_pkg::MB_M,
                  dst: rsu_pkg::DST_DEN};
        end
        if (status.done) state_next = rsu_pkg::ST_DIV;
      end
      rsu_pkg::ST_DIV: begin
        if (!(kind == rsu_pkg::STAT_SUM || kind == rsu_pkg::STAT_SUMSQ)) begin
          cmd.op = rsu_pkg::DP_DIV;
        end
        if (status.done) state_next = rsu_pkg::ST_SQRT;
      end
      rsu_pkg::ST_SQRT: begin
        case (kind)
          rsu_pkg::STAT_SSTD, rsu_pkg::STAT_PSTD, rsu_pkg::STAT_STDERR,
          rsu_pkg::STAT_CV, rsu_pkg::STAT_QMEAN: cmd.op = rsu_pkg::DP_SQRT;
          default: cmd.op = rsu_pkg::DP_NOP;
        endcase
        if (status.done) state_next = rsu_pkg::ST_OUT;
      end
      rsu_pkg::ST_OUT: begin
        // Wait until the output register is free.
        if (!result_valid || result_ready) begin
          cmd.op            = rsu_pkg::DP_OUT;
          result_valid_next = 1'b1;
          state_next        = rsu_pkg::ST_IDLE;
        end
      end
      default: state_next = rsu_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/rsu_datapath.sv
module rsu_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [47:0]       cfg_data,
  input  rsu_pkg::item_t    item,
  input  rsu_pkg::cmd_t     cmd,
  output rsu_pkg::status_t  status,
  output rsu_pkg::result_t  result
);

  localparam int SB   = SAMPLE_BITS;
  localparam int CB   = COUNT_BITS;
  localparam int AW   = SB + CB;
  localparam int QW   = 2 * SB + CB;
  localparam int W    = 3 * CB + 2 * SB + 32;
  localparam int MB   = AW;
  localparam int SQW  = (W + 1) / 2;
  localparam int EW   = (W > 64) ? W : 64;
  localparam int CW   = $clog2(W + 1);
  localparam logic [CW-1:0] MUL_LAST  = CW'(MB - 1);
  localparam logic [CW-1:0] DIV_LAST  = CW'(W - 1);
  localparam logic [CW-1:0] SQRT_LAST = CW'(SQW - 1);

  // Accumulator store.
  logic [CB-1:0]        count;
  logic signed [SB-1:0] rmin, rmax;
  logic signed [AW-1:0] rsum;
  logic [QW-1:0]        rsq;
  logic [47:0]          missing;

  // Query working registers.
  logic [3:0]    sel;
  logic [AW-1:0] absv;
  logic          negv;
  logic [W-1:0]  s2, d, num, den, res;
  logic          busy;
  logic [CW-1:0] step;
  logic [W-1:0]  mul_a;
  logic [MB-1:0] mul_b;
  logic [W:0]    rem;
  logic [2*SQW-1:0] sq_x;
  logic [SQW:0]     sq_rem;
  logic [SQW-1:0]   sq_root;

  // Sample decode for add.
  logic [SB+15:0]       sample_ext;
  logic signed [SB-1:0] s;
  logic [SB-1:0]        mag;
  logic [2*SB-1:0]      mag2;
  logic                 full;
  assign sample_ext = {{SB{1'b0}}, item.sample};
  assign s          = sample_ext[SB-1:0];
  assign mag        = s[SB-1] ? SB'(-s) : SB'(s);
  assign mag2       = mag * mag;
  assign full       = &count;

  // Count of the sample statistics divisor.
  logic [CB-1:0] mval;
  assign mval = (count <= CB'(1)) ? CB'(1) : count - CB'(1);

  // Wide operand select.
  logic [W-1:0] src_v;
  always_comb begin
    case (cmd.src)
      rsu_pkg::SRC_ABS16: src_v = W'(absv) << 16;
      rsu_pkg::SRC_SQ16:  src_v = W'(rsq) << 16;
      rsu_pkg::SRC_SQ32:  src_v = W'(rsq) << 32;
      rsu_pkg::SRC_D16:   src_v = d << 16;
      rsu_pkg::SRC_D32:   src_v = d << 32;
      rsu_pkg::SRC_N:     src_v = W'(count);
      rsu_pkg::SRC_NUM32: src_v = num << 32;
      rsu_pkg::SRC_ABS:   src_v = W'(absv);
      rsu_pkg::SRC_D:     src_v = d;
      rsu_pkg::SRC_DEN:   src_v = den;
      rsu_pkg::SRC_S2:    src_v = s2;
      rsu_pkg::SRC_SQ:    src_v = W'(rsq);
      default:            src_v = '0;
    endcase
  end

  logic [MB-1:0] mb_v;
  always_comb begin
    case (cmd.mb)
      rsu_pkg::MB_N:   mb_v = MB'(count);
      rsu_pkg::MB_M:   mb_v = MB'(mval);
      rsu_pkg::MB_ABS: mb_v = absv;
      default:         mb_v = '0;
    endcase
  end

  // One step of shift-add multiply, restoring divide and digit square root.
  logic [W-1:0]   mul_sum;
  logic [W:0]     div_sh;
  logic           div_bit;
  logic [SQW+2:0] sq_sh, sq_trial;
  logic           sq_bit;
  assign mul_sum  = res + (mul_b[0] ? mul_a : '0);
  assign div_sh   = {rem[W-1:0], num[W-1]};
  assign div_bit  = div_sh >= {1'b0, den};
  assign sq_sh    = {sq_rem, sq_x[2*SQW-1 -: 2]};
  assign sq_trial = (SQW+3)'({sq_root, 2'b01});
  assign sq_bit   = sq_sh >= sq_trial;

  logic [CW-1:0] last;
  always_comb begin
    case (cmd.op)
      rsu_pkg::DP_MUL:  last = MUL_LAST;
      rsu_pkg::DP_DIV:  last = DIV_LAST;
      rsu_pkg::DP_SQRT: last = SQRT_LAST;
      default:          last = '0;
    endcase
  end

  logic iterative, done;
  assign iterative = (cmd.op == rsu_pkg::DP_MUL) || (cmd.op == rsu_pkg::DP_DIV) ||
                     (cmd.op == rsu_pkg::DP_SQRT);
  assign done      = !iterative || (busy && step == last);

  // Status toward the controller.
  logic missing_q, abs_zero, sq_zero;
  assign abs_zero  = (absv == '0);
  assign sq_zero   = (rsq == '0);
  assign missing_q = (count == '0 && sel != rsu_pkg::STAT_COUNT) || (sel > rsu_pkg::STAT_COUNT);
  always_comb begin
    status.done   = done;
    status.sel    = sel;
    status.cv_var = abs_zero && !sq_zero;
    status.direct = missing_q || (sel == rsu_pkg::STAT_CV && abs_zero && sq_zero);
    case (sel)
      rsu_pkg::STAT_LOWEST, rsu_pkg::STAT_HIGHEST, rsu_pkg::STAT_RANGE,
      rsu_pkg::STAT_COUNT: status.direct = 1'b1;
      default: ;
    endcase
  end

  // Final value with saturation of the wide magnitude.
  logic [EW-1:0]      res_ext;
  logic               over, out_neg;
  logic signed [63:0] sat_v, out_v;
  logic [SB:0]        span;
  assign res_ext = EW'(res);
  assign over    = |res_ext[EW-1:63];
  assign out_neg = negv && (sel == rsu_pkg::STAT_MEAN || sel == rsu_pkg::STAT_SUM ||
                            sel == rsu_pkg::STAT_CV);
  assign span    = {rmax[SB-1], rmax} - {rmin[SB-1], rmin};
  always_comb begin
    if (over) sat_v = out_neg ? -64'sh7FFF_FFFF_FFFF_FFFF : 64'sh7FFF_FFFF_FFFF_FFFF;
    else      sat_v = out_neg ? -$signed({1'b0, res_ext[62:0]})
                              : $signed({1'b0, res_ext[62:0]});
    case (sel)
      rsu_pkg::STAT_LOWEST:  out_v = $signed({{(48-SB){rmin[SB-1]}}, rmin, 16'h0});
      rsu_pkg::STAT_HIGHEST: out_v = $signed({{(48-SB){rmax[SB-1]}}, rmax, 16'h0});
      rsu_pkg::STAT_RANGE:   out_v = $signed({{(47-SB){span[SB]}}, span, 16'h0});
      rsu_pkg::STAT_COUNT:   out_v = $signed({{(48-CB){1'b0}}, count, 16'h0});
      rsu_pkg::STAT_CV:      out_v = (abs_zero && sq_zero) ? 64'sh0 : sat_v;
      default:               out_v = sat_v;
    endcase
    if (missing_q) out_v = $signed({{16{missing[47]}}, missing});
  end

  // Store, configuration and query sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rmin    <= {1'b0, {(SB-1){1'b1}}};
      rmax    <= {1'b1, {(SB-1){1'b0}}};
      rsum    <= '0;
      rsq     <= '0;
      missing <= rsu_pkg::MISSING_RESET;
      busy    <= 1'b0;
    end else begin
      if (cfg_we) missing <= cfg_data;
      if (iterative) begin
        busy <= !done;
        step <= busy ? step + CW'(1) : '0;
      end
      case (cmd.op)
        rsu_pkg::DP_ADD: begin
          if (!full) begin
            count <= count + CB'(1);
            if (s < rmin) rmin <= s;
            if (s > rmax) rmax <= s;
            rsum <= rsum + AW'(s);
            rsq  <= rsq + QW'(mag2);
          end
        end
        rsu_pkg::DP_CLEAR: begin
          count <= '0;
          rmin  <= {1'b0, {(SB-1){1'b1}}};
          rmax  <= {1'b1, {(SB-1){1'b0}}};
          rsum  <= '0;
          rsq   <= '0;
        end
        rsu_pkg::DP_QUERY: begin
          sel  <= item.stat_select;
          negv <= rsum[AW-1];
          absv <= rsum[AW-1] ? AW'(-rsum) : AW'(rsum);
        end
        rsu_pkg::DP_LOAD: begin
          case (cmd.dst)
            rsu_pkg::DST_NUM: num <= src_v;
            rsu_pkg::DST_DEN: den <= src_v;
            default:          res <= src_v;
          endcase
        end
        rsu_pkg::DP_FIXD: d <= (d >= s2) ? d - s2 : '0;
        rsu_pkg::DP_MUL: begin
          if (!busy) begin
            res   <= '0;
            mul_a <= src_v;
            mul_b <= mb_v;
          end else begin
            res   <= mul_sum;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
            if (done) begin
              case (cmd.dst)
                rsu_pkg::DST_S2:  s2  <= mul_sum;
                rsu_pkg::DST_D:   d   <= mul_sum;
                rsu_pkg::DST_NUM: num <= mul_sum;
                rsu_pkg::DST_DEN: den <= mul_sum;
                default:          res <= mul_sum;
              endcase
            end
          end
        end
        rsu_pkg::DP_DIV: begin
          if (!busy) begin
            rem <= '0;
            res <= '0;
          end else begin
            rem <= div_bit ? div_sh - {1'b0, den} : div_sh;
            num <= num << 1;
            res <= {res[W-2:0], div_bit};
          end
        end
        rsu_pkg::DP_SQRT: begin
          if (!busy) begin
            sq_x    <= (2*SQW)'(res);
            sq_rem  <= '0;
            sq_root <= '0;
          end else begin
            sq_x    <= sq_x << 2;
            sq_rem  <= sq_bit ? (SQW+1)'(sq_sh - sq_trial) : (SQW+1)'(sq_sh);
            sq_root <= {sq_root[SQW-2:0], sq_bit};
            if (done) res <= W'({sq_root[SQW-2:0], sq_bit});
          end
        end
        rsu_pkg::DP_OUT: begin
          result.stat_value <= out_v;
          result.is_missing <= missing_q;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OPC_UNUSED = 2'd3;
  localparam int          COUNT_FULL = 65535;
  localparam longint      CYCLE_LIMIT = 3000000;
  localparam logic [47:0] MISS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MISS_MIN = 48'h8000_0000_0000;

  // Exact model of the statistics store and a queue of pending query answers.
  class stats_scoreboard;
    logic [47:0]      missing;
    int               cnt;
    longint           lo;
    longint           hi;
    longint           sum;
    longint           sq;
    rsu_pkg::result_t pending[$];
    int               errors;

    function void clear_store();
      cnt = 0;
      lo  = 32767;
      hi  = -32768;
      sum = 0;
      sq  = 0;
    endfunction

    function new();
      missing = rsu_pkg::MISSING_RESET;
      errors  = 0;
      clear_store();
    endfunction

    function logic [191:0] isqrt(logic [191:0] x);
      logic [191:0] r;
      logic [191:0] t;
      r = '0;
      for (int i = 95; i >= 0; i--) begin
        t = r | (192'd1 << i);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    // Clamp a magnitude into signed 64 bits and apply the sign.
    function logic [63:0] to_q(logic [191:0] mag, bit neg);
      logic [63:0] v;
      if (mag >= (192'd1 << 63)) v = 64'h7FFF_FFFF_FFFF_FFFF;
      else v = mag[63:0];
      return neg ? -v : v;
    endfunction

    // Fold an accepted input transaction into the store.
    function void note_item(rsu_pkg::item_t it);
      logic [191:0] wn, wm, as, s2, wsq, d, r;
      bit neg;
      rsu_pkg::result_t e;
      case (it.operation)
        rsu_pkg::OPC_ADD: begin
          if (cnt < COUNT_FULL) begin
            cnt++;
            if (longint'(it.sample) < lo) lo = it.sample;
            if (longint'(it.sample) > hi) hi = it.sample;
            sum += it.sample;
            sq  += longint'(it.sample) * longint'(it.sample);
          end
        end
        rsu_pkg::OPC_CLEAR: clear_store();
        rsu_pkg::OPC_QUERY: begin
          neg = sum < 0;
          as  = neg ? -sum : sum;
          wn  = cnt;
          wm  = (cnt <= 1) ? 1 : cnt - 1;
          wsq = sq;
          s2  = as * as;
          d   = wn * wsq;
          d   = (d >= s2) ? d - s2 : '0;
          e.is_missing = 1'b0;
          if ((cnt == 0 && it.stat_select != rsu_pkg::STAT_COUNT) ||
              it.stat_select > rsu_pkg::STAT_COUNT) begin
            e.is_missing = 1'b1;
            e.stat_value = {{16{missing[47]}}, missing};
          end else begin
            case (it.stat_select)
              rsu_pkg::STAT_LOWEST:  e.stat_value = lo * 65536;
              rsu_pkg::STAT_MEAN:    e.stat_value = to_q((as << 16) / wn, neg);
              rsu_pkg::STAT_SUM:     e.stat_value = to_q(as << 16, neg);
              rsu_pkg::STAT_SUMSQ:   e.stat_value = to_q(wsq << 16, 0);
              rsu_pkg::STAT_SSTD:
                e.stat_value = to_q(isqrt((d << 32) / (wn * wm)), 0);
              rsu_pkg::STAT_PSTD:
                e.stat_value = to_q(isqrt((d << 32) / (wn * wn)), 0);
              rsu_pkg::STAT_STDERR:
                e.stat_value = to_q(isqrt((d << 32) / (wn * wn * wm)), 0);
              rsu_pkg::STAT_CV: begin
                // A zero sum falls through to the variance unless all samples are zero.
                if (as == 0 && wsq != 0) r = to_q((d << 16) / (wn * wm), 0);
                else if (as == 0) r = '0;
                else r = to_q(isqrt(((d * wn) << 32) / (wm * s2)), neg);
                e.stat_value = r[63:0];
              end
              rsu_pkg::STAT_VAR:     e.stat_value = to_q((d << 16) / (wn * wm), 0);
              rsu_pkg::STAT_HIGHEST: e.stat_value = hi * 65536;
              rsu_pkg::STAT_TSS:     e.stat_value = to_q((d << 16) / wn, 0);
              rsu_pkg::STAT_QMEAN:   e.stat_value = to_q(isqrt((wsq << 32) / wn), 0);
              rsu_pkg::STAT_RANGE:   e.stat_value = (hi - lo) * 65536;
              default:               e.stat_value = longint'(cnt) * 65536;
            endcase
          end
          pending.insert(pending.size(), e);
        end
        default: ;
      endcase
    endfunction

    // Compare a result transaction with the oldest pending answer.
    function void check_result(rsu_pkg::result_t got);
      rsu_pkg::result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d missing=%0b", $time,
                 got.stat_value, got.is_missing);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.stat_value !== e.stat_value) begin
        $display("%0t: stat_value expected %0d actual %0d", $time,
                 e.stat_value, got.stat_value);
        errors++;
      end
      if (got.is_missing !== e.is_missing) begin
        $display("%0t: is_missing expected %0b actual %0b", $time,
                 e.is_missing, got.is_missing);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [47:0]      cfg_data = '0;
  logic             item_valid = 1'b0;
  logic             item_ready;
  rsu_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  rsu_pkg::result_t result;

  stats_scoreboard sb = new();
  longint cycles = 0;
  int     hold_off = 0;
  int     sent = 0;

  running_statistics_unit_core dut (
    .clk, .rst, .cfg_we, .cfg_data, .item_valid, .item_ready, .item,
    .result_valid, .result_ready, .result
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls per result, with an occasional long hold-off.
  initial begin
    int w;
    forever begin
      w = $urandom_range(0, 4);
      if (hold_off > 0) begin
        w = hold_off;
        hold_off = 0;
      end
      repeat (w) begin
        @(negedge clk);
        result_ready = 1'b0;
      end
      @(negedge clk);
      result_ready = 1'b1;
      do @(posedge clk); while (!(result_valid && !rst));
      sb.check_result(result);
    end
  end

  // Offer one input transaction after a gap and wait until it is taken.
  task automatic send(logic [1:0] op, logic [15:0] smp, logic [3:0] sel, int gap);
    repeat (gap) begin
      @(negedge clk);
      item_valid = 1'b0;
    end
    @(negedge clk);
    item.operation   = op;
    item.sample      = smp;
    item.stat_select = sel;
    item_valid       = 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_item(item);
    sent++;
  endtask

  task automatic send_rand(logic [1:0] op, logic [15:0] smp, logic [3:0] sel);
    send(op, smp, sel, $urandom_range(0, 4));
  endtask

  // Stop sending and wait until every pending answer has arrived.
  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_missing(logic [47:0] v);
    drain();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.missing = v;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic query_all();
    for (int s = 0; s < 16; s++) send_rand(rsu_pkg::OPC_QUERY, 16'($urandom), 4'(s));
  endtask

  // Main stimulus sequence.
  initial begin
    int k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty store, extremes, zero-sum cases and unused codes.
    send_rand(rsu_pkg::OPC_QUERY, 16'h0, rsu_pkg::STAT_MEAN);
    send_rand(rsu_pkg::OPC_QUERY, 16'h0, rsu_pkg::STAT_COUNT);
    send_rand(rsu_pkg::OPC_ADD, 16'h7FFF, 4'hF);
    send_rand(rsu_pkg::OPC_ADD, 16'h8000, 4'h0);
    send_rand(OPC_UNUSED, 16'h1234, rsu_pkg::STAT_COUNT);
    query_all();
    send_rand(rsu_pkg::OPC_CLEAR, 16'hFFFF, 4'hF);
    send_rand(rsu_pkg::OPC_ADD, 16'd5, rsu_pkg::STAT_LOWEST);
    send_rand(rsu_pkg::OPC_ADD, -16'sd5, rsu_pkg::STAT_LOWEST);
    send_rand(rsu_pkg::OPC_QUERY, 16'h0, rsu_pkg::STAT_CV);
    send_rand(rsu_pkg::OPC_CLEAR, 16'h0, rsu_pkg::STAT_LOWEST);
    send_rand(rsu_pkg::OPC_ADD, 16'h0, rsu_pkg::STAT_LOWEST);
    send_rand(rsu_pkg::OPC_QUERY, 16'h0, rsu_pkg::STAT_CV);
    send_rand(rsu_pkg::OPC_QUERY, 16'h0, rsu_pkg::STAT_RANGE);

    write_missing(MISS_MAX);

    // Every statistic of an empty store with the largest missing value.
    send(rsu_pkg::OPC_CLEAR, 16'h0, rsu_pkg::STAT_LOWEST, 0);
    query_all();

    // Long receiver hold-off while queries keep coming, so the input stalls.
    drain();
    hold_off = 2000;
    for (int i = 0; i < 6; i++)
      send(rsu_pkg::OPC_QUERY, 16'h0, 4'($urandom_range(0, 13)), 0);

    write_missing(MISS_MIN);
    write_missing(48'h0);

    // Random phases: an optional clear, a batch of adds, then a few queries.
    while (sent < 1150) begin
      if ($urandom_range(0, 19) == 0) write_missing(48'($urandom) << 16 | 48'($urandom));
      if ($urandom_range(0, 3) != 0)
        send_rand(rsu_pkg::OPC_CLEAR, 16'($urandom), 4'($urandom));
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 30) == 0) send_rand(OPC_UNUSED, 16'($urandom), 4'($urandom));
        else send_rand(rsu_pkg::OPC_ADD, rand_sample(), 4'($urandom));
      end
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++)
        send_rand(rsu_pkg::OPC_QUERY, 16'($urandom),
                  ($urandom_range(0, 15) == 0) ? 4'($urandom_range(14, 15))
                                                : 4'($urandom_range(0, 13)));
    end
    write_missing(rsu_pkg::MISSING_RESET);
    send_rand(rsu_pkg::OPC_QUERY, 16'h0, rsu_pkg::STAT_SUM);

    drain();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rsu_pkg.sv
rtl/rsu_ctrl.sv
rtl/rsu_datapath.sv
rtl/running_statistics_unit_core.sv
sim/tb_top.sv
